>>> sv/assert_macros.svh
// Assertion macros for the RTL, included by rsqs_front.
// Each macro checks a property on the rising edge of clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/rsqs_pkg.sv
package rsqs_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int DIR_W   = 16;
    localparam int PROD_W  = COORD_W + DIR_W;
    // Two products plus the rounding constant, with headroom
    localparam int SUM_W   = PROD_W + 2;
    // Q1.14 scale plus the halving of the size
    localparam int FRAC_SHIFT = 15;
    // Shifted offset plus centre, before saturation
    localparam int POS_W   = SUM_W - FRAC_SHIFT + 1;
    localparam int TEX_W   = COORD_W + 1;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_SHIFT - 1);

    // Corner codes
    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    // One sprite as held for its four corners
    typedef struct packed {
        logic signed [PROD_W-1:0]  dcw;   // cos * width
        logic signed [PROD_W-1:0]  dsh;   // sin * height
        logic signed [PROD_W-1:0]  dsw;   // sin * width
        logic signed [PROD_W-1:0]  dch;   // cos * height
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] ux;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] uw;
        logic signed [COORD_W-1:0] vh;
        logic [COORD_W-1:0]        depth;
        logic [COORD_W-1:0]        rgba;
    } sprite_t;

    // One corner after offset combination
    typedef struct packed {
        logic [1:0]                corner;
        logic signed [SUM_W-1:0]   tx;
        logic signed [SUM_W-1:0]   ty;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
        logic [COORD_W-1:0]        depth;
        logic [COORD_W-1:0]        rgba;
    } corner_t;

    // Clamp a texture sum to the signed 32 bit range
    function automatic logic signed [COORD_W-1:0] sat_tex(input logic signed [TEX_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[TEX_W-1] != v[COORD_W-1])
            r = v[TEX_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    // Clamp a position sum to the signed 32 bit range
    function automatic logic signed [COORD_W-1:0] sat_pos(input logic signed [POS_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[POS_W-1:COORD_W-1] != {(POS_W-COORD_W+1){v[POS_W-1]}})
            r = v[POS_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

>>> sv/rsqs_front.sv
`include "assert_macros.svh"

module rsqs_front
    import rsqs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic signed [COORD_W-1:0] size_w,
    input  logic signed [COORD_W-1:0] size_h,
    input  logic signed [DIR_W-1:0]   dir_cos,
    input  logic signed [DIR_W-1:0]   dir_sin,
    input  logic signed [COORD_W-1:0] tex_x,
    input  logic signed [COORD_W-1:0] tex_y,
    input  logic signed [COORD_W-1:0] tex_w,
    input  logic signed [COORD_W-1:0] tex_h,
    input  logic [COORD_W-1:0]        depth_bits,
    input  logic [COORD_W-1:0]        rgba,
    output sprite_t                   sprite,
    output logic                      valid,
    output logic [1:0]                corner
);

    logic       accept;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] corner_reg;
    logic [1:0] corner_next;
    sprite_t    sprite_reg;
    sprite_t    sprite_next;

    // Take a new word while the last corner of the current sprite goes out
    assign busy   = valid_reg && (corner_reg != CORNER_LAST);
    assign accept = start && !busy;

    // Step through the four corners
    always_comb
    begin
        valid_next  = valid_reg;
        corner_next = corner_reg;
        if (accept)
        begin
            valid_next  = 1'b1;
            corner_next = CORNER_FIRST;
        end
        else if (valid_reg)
        begin
            corner_next = corner_reg + 2'd1;
            if (corner_reg == CORNER_LAST)
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            corner_reg <= CORNER_FIRST;
        end
        else
        begin
            valid_reg  <= valid_next;
            corner_reg <= corner_next;
        end
    end

    // Form the four rotation products once per sprite
    always_comb
    begin
        sprite_next = sprite_reg;
        if (accept)
        begin
            sprite_next.dcw   = PROD_W'(dir_cos) * PROD_W'(size_w);
            sprite_next.dsh   = PROD_W'(dir_sin) * PROD_W'(size_h);
            sprite_next.dsw   = PROD_W'(dir_sin) * PROD_W'(size_w);
            sprite_next.dch   = PROD_W'(dir_cos) * PROD_W'(size_h);
            sprite_next.cx    = center_x;
            sprite_next.cy    = center_y;
            sprite_next.ux    = tex_x;
            sprite_next.vy    = tex_y;
            sprite_next.uw    = tex_w;
            sprite_next.vh    = tex_h;
            sprite_next.depth = depth_bits;
            sprite_next.rgba  = rgba;
        end
    end

    always_ff @(posedge clk)
    begin
        sprite_reg <= sprite_next;
    end

    assign sprite = sprite_reg;
    assign valid  = valid_reg;
    assign corner = corner_reg;

    `ASSERT_NEXT(a_accept_starts, accept, valid_reg && (corner_reg == CORNER_FIRST))
    `ASSERT_NEXT(a_corner_steps, valid_reg && (corner_reg != CORNER_LAST),
                 valid_reg && (corner_reg == $past(corner_reg) + 2'd1))
    `ASSERT_NEXT(a_idle_after_last, valid_reg && (corner_reg == CORNER_LAST) && !start,
                 !valid_reg)

endmodule

>>> sv/rsqs_corner.sv
module rsqs_corner
    import rsqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sprite_t    sprite,
    input  logic       valid,
    input  logic [1:0] corner,
    output corner_t    cor,
    output logic       cor_valid
);

    logic                      side_x;
    logic                      side_y;
    logic signed [SUM_W-1:0]   a_cw;
    logic signed [SUM_W-1:0]   a_sh;
    logic signed [SUM_W-1:0]   a_sw;
    logic signed [SUM_W-1:0]   a_ch;
    logic signed [SUM_W-1:0]   ow_x;
    logic signed [SUM_W-1:0]   oh_x;
    logic signed [SUM_W-1:0]   ow_y;
    logic signed [SUM_W-1:0]   oh_y;
    logic signed [TEX_W-1:0]   u_sum;
    logic signed [TEX_W-1:0]   v_sum;
    logic                      valid_reg;
    corner_t                   cor_reg;
    corner_t                   cor_next;

    assign side_x = corner[1];
    assign side_y = corner[0];

    // Widen the products before signing them
    assign a_cw = SUM_W'(sprite.dcw);
    assign a_sh = SUM_W'(sprite.dsh);
    assign a_sw = SUM_W'(sprite.dsw);
    assign a_ch = SUM_W'(sprite.dch);

    // Pick the sign of each half-size term for this corner
    assign ow_x = side_x ? a_cw : -a_cw;
    assign oh_x = side_y ? a_sh : -a_sh;
    assign ow_y = side_x ? a_sw : -a_sw;
    assign oh_y = side_y ? a_ch : -a_ch;

    // Texture origin plus the rectangle size on the far sides
    assign u_sum = TEX_W'(sprite.ux) + (side_x ? TEX_W'(sprite.uw) : TEX_W'(0));
    assign v_sum = TEX_W'(sprite.vy) + (side_y ? TEX_W'(sprite.vh) : TEX_W'(0));

    always_comb
    begin
        cor_next.corner = corner;
        cor_next.tx     = ow_x - oh_x + ROUND_HALF;
        cor_next.ty     = ow_y + oh_y + ROUND_HALF;
        cor_next.cx     = sprite.cx;
        cor_next.cy     = sprite.cy;
        cor_next.tex_u  = sat_tex(u_sum);
        cor_next.tex_v  = sat_tex(v_sum);
        cor_next.depth  = sprite.depth;
        cor_next.rgba   = sprite.rgba;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        cor_reg <= cor_next;
    end

    assign cor       = cor_reg;
    assign cor_valid = valid_reg;

endmodule

>>> sv/rsqs_out.sv
module rsqs_out
    import rsqs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  corner_t                   cor,
    input  logic                      cor_valid,
    output logic                      strobe,
    output logic [1:0]                corner,
    output logic signed [COORD_W-1:0] pos_x,
    output logic signed [COORD_W-1:0] pos_y,
    output logic signed [COORD_W-1:0] tex_u,
    output logic signed [COORD_W-1:0] tex_v,
    output logic [COORD_W-1:0]        depth_out,
    output logic [COORD_W-1:0]        rgba_out,
    output logic                      last
);

    logic signed [POS_W-1:0]   px_wide;
    logic signed [POS_W-1:0]   py_wide;
    logic                      strobe_reg;
    logic [1:0]                corner_reg;
    logic signed [COORD_W-1:0] pos_x_reg;
    logic signed [COORD_W-1:0] pos_y_reg;
    logic signed [COORD_W-1:0] tex_u_reg;
    logic signed [COORD_W-1:0] tex_v_reg;
    logic [COORD_W-1:0]        depth_reg;
    logic [COORD_W-1:0]        rgba_reg;
    logic                      last_reg;

    // Drop the fraction (rounding already added) and add the centre
    assign px_wide = POS_W'(cor.tx >>> FRAC_SHIFT) + POS_W'(cor.cx);
    assign py_wide = POS_W'(cor.ty >>> FRAC_SHIFT) + POS_W'(cor.cy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cor_valid;
    end

    // Hold the word for its single output cycle
    always_ff @(posedge clk)
    begin
        corner_reg <= cor.corner;
        pos_x_reg  <= sat_pos(px_wide);
        pos_y_reg  <= sat_pos(py_wide);
        tex_u_reg  <= cor.tex_u;
        tex_v_reg  <= cor.tex_v;
        depth_reg  <= cor.depth;
        rgba_reg   <= cor.rgba;
        last_reg   <= (cor.corner == CORNER_LAST);
    end

    assign strobe    = strobe_reg;
    assign corner    = corner_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;
    assign depth_out = depth_reg;
    assign rgba_out  = rgba_reg;
    assign last      = last_reg;

endmodule

>>> sv/rotated_sprite_quad_setup.sv
// Sprite quad setup with rotation. Pulse start with a sprite on the input ports while busy
// is low; the block turns it into four corner words, (0,0), (0,1), (1,0), (1,1), given one
// per cycle with strobe high, the first once the sprite has passed the sequencer, corner and
// output registers. The receiver cannot stall: each word is on the ports for one cycle only.
// The corner sequencer steps one corner per cycle; busy drops while the last corner is formed,
// so sprites issued back to back stream without gaps. The four 16x32 rotation products are
// formed once per sprite as it is accepted.
module rotated_sprite_quad_setup
    import rsqs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic signed [COORD_W-1:0] size_w,
    input  logic signed [COORD_W-1:0] size_h,
    input  logic signed [DIR_W-1:0]   dir_cos,
    input  logic signed [DIR_W-1:0]   dir_sin,
    input  logic signed [COORD_W-1:0] tex_x,
    input  logic signed [COORD_W-1:0] tex_y,
    input  logic signed [COORD_W-1:0] tex_w,
    input  logic signed [COORD_W-1:0] tex_h,
    input  logic [COORD_W-1:0]        depth_bits,
    input  logic [COORD_W-1:0]        rgba,
    output logic                      strobe,
    output logic [1:0]                corner,
    output logic signed [COORD_W-1:0] pos_x,
    output logic signed [COORD_W-1:0] pos_y,
    output logic signed [COORD_W-1:0] tex_u,
    output logic signed [COORD_W-1:0] tex_v,
    output logic [COORD_W-1:0]        depth_out,
    output logic [COORD_W-1:0]        rgba_out,
    output logic                      last
);

    sprite_t    sprite;
    logic       seq_valid;
    logic [1:0] seq_corner;
    corner_t    cor;
    logic       cor_valid;

    // Accept sprites, form products, sequence corners
    rsqs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .center_x   (center_x),
        .center_y   (center_y),
        .size_w     (size_w),
        .size_h     (size_h),
        .dir_cos    (dir_cos),
        .dir_sin    (dir_sin),
        .tex_x      (tex_x),
        .tex_y      (tex_y),
        .tex_w      (tex_w),
        .tex_h      (tex_h),
        .depth_bits (depth_bits),
        .rgba       (rgba),
        .sprite     (sprite),
        .valid      (seq_valid),
        .corner     (seq_corner)
    );

    // Combine signed offsets and texture sums per corner
    rsqs_corner u_corner (
        .clk       (clk),
        .rst_n     (rst_n),
        .sprite    (sprite),
        .valid     (seq_valid),
        .corner    (seq_corner),
        .cor       (cor),
        .cor_valid (cor_valid)
    );

    // Drop the fraction, add centre, saturate, present the word
    rsqs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cor       (cor),
        .cor_valid (cor_valid),
        .strobe    (strobe),
        .corner    (corner),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .tex_u     (tex_u),
        .tex_v     (tex_v),
        .depth_out (depth_out),
        .rgba_out  (rgba_out),
        .last      (last)
    );

endmodule

>>> verif/rotated_sprite_quad_setup_test.sv
`timescale 1ns / 1ps

module rotated_sprite_quad_setup_test;
    import rsqs_pkg::*;

    // One sprite as offered on the input ports
    typedef struct {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] size_w;
        logic signed [COORD_W-1:0] size_h;
        logic signed [DIR_W-1:0]   dir_cos;
        logic signed [DIR_W-1:0]   dir_sin;
        logic signed [COORD_W-1:0] tex_x;
        logic signed [COORD_W-1:0] tex_y;
        logic signed [COORD_W-1:0] tex_w;
        logic signed [COORD_W-1:0] tex_h;
        logic [COORD_W-1:0]        depth_bits;
        logic [COORD_W-1:0]        rgba;
    } sprite_t;

    // One corner word as seen on the result ports
    typedef struct {
        logic [1:0]                corner;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
        logic [COORD_W-1:0]        depth_out;
        logic [COORD_W-1:0]        rgba_out;
        logic                      last;
    } corner_word_t;

    // Expands each accepted sprite into its four corner words and checks them in order
    class corner_ledger;
        corner_word_t pending_corners[$];
        int unsigned  fail_count = 0;

        function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[COORD_W-1:0];
        endfunction

        function void note_sprite(input sprite_t s);
            longint       w;
            longint       h;
            longint       dc;
            longint       ds;
            longint       ow;
            longint       oh;
            longint       tx;
            longint       ty;
            longint       xs;
            longint       ys;
            corner_word_t cw;
            w  = longint'(s.size_w);
            h  = longint'(s.size_h);
            dc = longint'(s.dir_cos);
            ds = longint'(s.dir_sin);
            for (int k = 0; k < 4; k++)
            begin
                xs = longint'(k >> 1);
                ys = longint'(k & 1);
                ow = xs ? w : -w;
                oh = ys ? h : -h;
                tx = dc * ow - ds * oh;
                ty = ds * ow + dc * oh;
                cw.corner    = k[1:0];
                // round to nearest, ties upward: floor of (t + half) / 2^15
                cw.pos_x     = clamp32(longint'(s.center_x) + ((tx + 64'sd16384) >>> 15));
                cw.pos_y     = clamp32(longint'(s.center_y) + ((ty + 64'sd16384) >>> 15));
                cw.tex_u     = clamp32(longint'(s.tex_x) + xs * longint'(s.tex_w));
                cw.tex_v     = clamp32(longint'(s.tex_y) + ys * longint'(s.tex_h));
                cw.depth_out = s.depth_bits;
                cw.rgba_out  = s.rgba;
                cw.last      = (k[1:0] == CORNER_LAST);
                pending_corners.push_back(cw);
            end
        endfunction

        function void compare_field(input string name, input logic [COORD_W-1:0] want,
                                    input logic [COORD_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, got %h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_corner(input corner_word_t got);
            corner_word_t want;
            if (pending_corners.size() == 0)
            begin
                $error("corner word with nothing outstanding: corner %0d", got.corner);
                fail_count++;
                return;
            end
            want = pending_corners.pop_front();
            compare_field("corner", COORD_W'(want.corner), COORD_W'(got.corner));
            compare_field("pos_x", want.pos_x, got.pos_x);
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("tex_u", want.tex_u, got.tex_u);
            compare_field("tex_v", want.tex_v, got.tex_v);
            compare_field("depth_out", want.depth_out, got.depth_out);
            compare_field("rgba_out", want.rgba_out, got.rgba_out);
            compare_field("last", COORD_W'(want.last), COORD_W'(got.last));
        endfunction

        function int outstanding();
            return pending_corners.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] center_x = '0;
    logic signed [COORD_W-1:0] center_y = '0;
    logic signed [COORD_W-1:0] size_w = '0;
    logic signed [COORD_W-1:0] size_h = '0;
    logic signed [DIR_W-1:0]   dir_cos = '0;
    logic signed [DIR_W-1:0]   dir_sin = '0;
    logic signed [COORD_W-1:0] tex_x = '0;
    logic signed [COORD_W-1:0] tex_y = '0;
    logic signed [COORD_W-1:0] tex_w = '0;
    logic signed [COORD_W-1:0] tex_h = '0;
    logic [COORD_W-1:0]        depth_bits = '0;
    logic [COORD_W-1:0]        rgba = '0;
    logic                      strobe;
    logic [1:0]                corner;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;
    logic [COORD_W-1:0]        depth_out;
    logic [COORD_W-1:0]        rgba_out;
    logic                      last;

    corner_ledger ledger = new();

    rotated_sprite_quad_setup i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .center_x   (center_x),
        .center_y   (center_y),
        .size_w     (size_w),
        .size_h     (size_h),
        .dir_cos    (dir_cos),
        .dir_sin    (dir_sin),
        .tex_x      (tex_x),
        .tex_y      (tex_y),
        .tex_w      (tex_w),
        .tex_h      (tex_h),
        .depth_bits (depth_bits),
        .rgba       (rgba),
        .strobe     (strobe),
        .corner     (corner),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .tex_u      (tex_u),
        .tex_v      (tex_v),
        .depth_out  (depth_out),
        .rgba_out   (rgba_out),
        .last       (last)
    );

    always #2 clk = ~clk;

    // Check every strobed corner word at the edge that ends its cycle
    always @(posedge clk)
    begin
        corner_word_t got;
        if (rst_n && strobe)
        begin
            got.corner    = corner;
            got.pos_x     = pos_x;
            got.pos_y     = pos_y;
            got.tex_u     = tex_u;
            got.tex_v     = tex_v;
            got.depth_out = depth_out;
            got.rgba_out  = rgba_out;
            got.last      = last;
            ledger.check_corner(got);
        end
    end

    function automatic sprite_t make_sprite(
        input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] w,
        input logic [31:0] h, input logic [15:0] dc, input logic [15:0] ds,
        input logic [31:0] ux, input logic [31:0] vy, input logic [31:0] uw,
        input logic [31:0] vh, input logic [31:0] dep, input logic [31:0] col);
        sprite_t s;
        s.center_x   = cx;
        s.center_y   = cy;
        s.size_w     = w;
        s.size_h     = h;
        s.dir_cos    = dc;
        s.dir_sin    = ds;
        s.tex_x      = ux;
        s.tex_y      = vy;
        s.tex_w      = uw;
        s.tex_h      = vh;
        s.depth_bits = dep;
        s.rgba       = col;
        return s;
    endfunction

    // Mostly screen-sized sprites with direction parts within the unit range, some fully random words
    function automatic sprite_t random_sprite();
        sprite_t s;
        s = make_sprite($urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                        $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 2) != 0)
        begin
            s.center_x = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
            s.center_y = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
            s.size_w   = $signed($urandom_range(0, 32'h007f_ffff)) - 32'sh0010_0000;
            s.size_h   = $signed($urandom_range(0, 32'h007f_ffff)) - 32'sh0010_0000;
            s.dir_cos  = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            s.dir_sin  = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            s.tex_x    = $urandom_range(0, 32'h0001_0000);
            s.tex_y    = $urandom_range(0, 32'h0001_0000);
            s.tex_w    = $urandom_range(0, 32'h0001_0000);
            s.tex_h    = $urandom_range(0, 32'h0001_0000);
        end
        return s;
    endfunction

    // Offer one sprite and hold it until the block takes it
    task automatic send_sprite(input sprite_t s);
        start      <= 1'b1;
        center_x   <= s.center_x;
        center_y   <= s.center_y;
        size_w     <= s.size_w;
        size_h     <= s.size_h;
        dir_cos    <= s.dir_cos;
        dir_sin    <= s.dir_sin;
        tex_x      <= s.tex_x;
        tex_y      <= s.tex_y;
        tex_w      <= s.tex_w;
        tex_h      <= s.tex_h;
        depth_bits <= s.depth_bits;
        rgba       <= s.rgba;
        do
            @(posedge clk);
        while (busy);
        ledger.note_sprite(s);
    endtask

    // Drop start for a random number of cycles unless in the gap-free stretch
    task automatic idle_some(input bit gap_free);
        if (!gap_free)
        begin
            while ($urandom_range(0, 99) < 24)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sprites: plain, rotated, degenerate and saturating cases
        idle_some(0);
        send_sprite(make_sprite(32'h0064_0000, 32'h0032_0000, 32'h0020_0000, 32'h0010_0000,
                                16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0001_0000,
                                32'h0001_0000, 32'h3f80_0000, 32'hff00_00ff));
        idle_some(0);
        send_sprite(make_sprite(32'h0064_0000, 32'h0032_0000, 32'h0020_0000, 32'h0010_0000,
                                16'sd0, 16'sd16384, 32'h0000_8000, 32'h0000_4000,
                                32'h0000_4000, 32'h0000_2000, 32'h1234_5678, 32'h80ff_40c0));
        idle_some(0);
        send_sprite(make_sprite(32'hfff0_0000, 32'h0010_0000, 32'h0008_0000, 32'h0004_0000,
                                -16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0001_0000,
                                32'h0001_0000, 32'h0, 32'hffff_ffff));
        idle_some(0);
        send_sprite(make_sprite(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0005_0000,
                                16'sd11585, 16'sd11585, 32'h0, 32'h0, 32'h0001_0000,
                                32'h0001_0000, 32'haaaa_aaaa, 32'h5555_5555));
        // zero direction puts every corner on the centre
        idle_some(0);
        send_sprite(make_sprite(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff, 32'h8000_0000,
                                16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0, 32'h0,
                                32'h5555_5555, 32'haaaa_aaaa));
        // direction not of unit length
        idle_some(0);
        send_sprite(make_sprite(32'h0000_0000, 32'h0000_0000, 32'h0040_0000, 32'h0020_0000,
                                16'sd8000, 16'sd3000, 32'h0, 32'h0, 32'h0001_0000,
                                32'h0001_0000, 32'h0, 32'h0));
        // direction beyond the unit range at both ends
        idle_some(0);
        send_sprite(make_sprite(32'h0010_0000, 32'hfff0_0000, 32'h0011_0000, 32'h0007_0000,
                                16'sh8000, 16'sh7fff, 32'h0, 32'h0, 32'h0001_0000,
                                32'h0001_0000, 32'h0, 32'h0));
        idle_some(0);
        send_sprite(make_sprite(32'h0010_0000, 32'hfff0_0000, 32'h0011_0000, 32'h0007_0000,
                                16'sh7fff, 16'sh8000, 32'h0, 32'h0, 32'h0001_0000,
                                32'h0001_0000, 32'h0, 32'h0));
        // negative sizes mirror the quad
        idle_some(0);
        send_sprite(make_sprite(32'h0050_0000, 32'h0050_0000, 32'hffec_0000, 32'hfff6_0000,
                                16'sd14189, 16'sd8192, 32'h0001_0000, 32'h0001_0000,
                                32'hffff_0000, 32'hffff_0000, 32'h0, 32'h0));
        // positions pushed past both ends of the range
        idle_some(0);
        send_sprite(make_sprite(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                16'sh8000, 16'sh8000, 32'h0, 32'h0, 32'h0, 32'h0,
                                32'h0, 32'h0));
        idle_some(0);
        send_sprite(make_sprite(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                16'sh7fff, 16'sh7fff, 32'h0, 32'h0, 32'h0, 32'h0,
                                32'h0, 32'h0));
        idle_some(0);
        send_sprite(make_sprite(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                16'sh8000, 16'sh7fff, 32'h0, 32'h0, 32'h0, 32'h0,
                                32'h0, 32'h0));
        // texture sums saturating high and low
        idle_some(0);
        send_sprite(make_sprite(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                                16'sd16384, 16'sd0, 32'h7fff_ffff, 32'h8000_0000,
                                32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0));
        idle_some(0);
        send_sprite(make_sprite(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                                16'sd16384, 16'sd0, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0));
        // all zeros, then all ones
        idle_some(0);
        send_sprite(make_sprite(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0,
                                32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        idle_some(0);
        send_sprite(make_sprite(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        // rounding ties on odd sizes
        idle_some(0);
        send_sprite(make_sprite(32'h0, 32'h0, 32'h1, 32'h1, 16'sd16384, 16'sd0,
                                32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        idle_some(0);
        send_sprite(make_sprite(32'h0, 32'h0, 32'h3, 32'hffff_fffd, 16'sd16384, 16'sd16384,
                                32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));

        // Random sprites, with one full drain partway and a stretch without gaps
        for (int i = 0; i < 152; i++)
        begin
            if (i == 80)
            begin
                start <= 1'b0;
                do
                    @(posedge clk);
                while (ledger.outstanding() != 0);
            end
            idle_some(i >= 100 && i < 140);
            send_sprite(random_sprite());
        end

        // Drain the remaining corner words and let the block settle
        start <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (ledger.fail_count == 0)
            $display("rotated_sprite_quad_setup: match");
        else
            $display("rotated_sprite_quad_setup: mismatch");
        $finish;
    end

    // Abandon a hung run
    initial
    begin
        #200000;
        $display("rotated_sprite_quad_setup: mismatch");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/rsqs_pkg.sv
sv/rsqs_front.sv
sv/rsqs_corner.sv
sv/rsqs_out.sv
sv/rotated_sprite_quad_setup.sv
verif/rotated_sprite_quad_setup_test.sv
